[src/tbd_pkg.sv]
`default_nettype none

package tbd_pkg;

    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned SUM_W     = 12;
    localparam int unsigned SEEN_W    = 5;
    localparam int unsigned CAL_SHIFT = 4;     // 16 calibration samples
    localparam logic [SEEN_W-1:0] CAL_SAMPLES = SEEN_W'(16);
    localparam int unsigned TDATA_W   = 16;

    typedef struct packed {
        logic               touched;
        logic               calibrating;
        logic [COUNT_W-1:0] baseline;
    } result_t;

endpackage

`default_nettype wire

[src/touch_baseline_detector.sv]
// An accepted count's result is registered into the output register, or into the skid
// register while that is held. Throughput: one count per clock while s_tready is high;
// the baseline update is a single pass of shifts, adds/subtracts and compares on the
// 8-bit baseline. A two-entry output buffer (result register plus skid) keeps s_tready
// high while one result waits. Reset (aresetn low, synchronous) clears the baseline,
// the calibration sum and sample count, and empties the output buffer.
`default_nettype none

module touch_baseline_detector (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] count
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] touched, [8:1] baseline, [15:9] zero
    output logic             m_tuser    // [0] calibrating
);
    import tbd_pkg::*;

    logic [COUNT_W-1:0] rest_level_reg, rest_level_next;
    logic [SUM_W-1:0]   cal_sum_reg, cal_sum_next;
    logic [SEEN_W-1:0]  cal_seen_reg, cal_seen_next;

    result_t out_reg, skid_reg, res_next;
    logic    out_valid_reg, skid_valid_reg;

    logic               accept, pop, to_out;
    logic [COUNT_W-1:0] cnt, base, trip;
    logic [SEEN_W-1:0]  seen_inc;
    logic [SUM_W-1:0]   sum_inc;

    assign cnt      = s_tdata;
    assign base     = rest_level_reg;
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    // new result goes straight to the output register when that slot frees up
    assign to_out   = !out_valid_reg || (pop && !skid_valid_reg);

    assign seen_inc = cal_seen_reg + SEEN_W'(1);
    assign sum_inc  = cal_sum_reg + SUM_W'(cnt);
    assign trip     = base - (base >> 2);

    always_comb begin
        rest_level_next = rest_level_reg;
        cal_sum_next    = cal_sum_reg;
        cal_seen_next   = cal_seen_reg;
        res_next.touched     = 1'b0;
        res_next.calibrating = 1'b0;
        if (cal_seen_reg < CAL_SAMPLES) begin
            res_next.calibrating = 1'b1;
            cal_sum_next  = sum_inc;
            cal_seen_next = seen_inc;
            if (seen_inc >= CAL_SAMPLES) begin
                rest_level_next = sum_inc[SUM_W-1:CAL_SHIFT];
            end
        end else if (cnt < trip) begin
            res_next.touched = 1'b1;
        end else if (cnt > base) begin
            rest_level_next = cnt;
        end else begin
            rest_level_next = base - (base >> CAL_SHIFT) + (cnt >> CAL_SHIFT);
        end
        res_next.baseline = rest_level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rest_level_reg <= '0;
            cal_sum_reg    <= '0;
            cal_seen_reg   <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                rest_level_reg <= rest_level_next;
                cal_sum_reg    <= cal_sum_next;
                cal_seen_reg   <= cal_seen_next;
            end
            // skid holds a result only while s_tready is low, so no accept here
            if (pop && skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (accept && to_out) begin
                out_reg       <= res_next;
                out_valid_reg <= 1'b1;
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
            if (accept && !to_out) begin
                skid_reg       <= res_next;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - COUNT_W - 1)'(0), out_reg.baseline, out_reg.touched};
    assign m_tuser  = out_reg.calibrating;

    a_no_touch_while_cal : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_reg.touched && out_reg.calibrating))
        else $error("touch reported during calibration");

    a_skid_needs_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_seen_saturates : assert property (@(posedge aclk) disable iff (!aresetn)
        cal_seen_reg <= CAL_SAMPLES)
        else $error("calibration sample count overran");

    a_baseline_frozen_on_touch : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res_next.touched) |=> (rest_level_reg == $past(rest_level_reg)))
        else $error("baseline moved on a touch");

endmodule

`default_nettype wire
